FILE: design/dbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbq_pkg: shared types, constants and ring helpers for the double-ended queue
// Port payload types, operation and status codes, storage geometry.
// ----------------------------------------------------------------------------
package dbq_pkg;

    // Storage geometry
    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed port field widths
    localparam int FIELD_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int POS_W    = 6;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;

    typedef logic signed [FIELD_W-1:0] field_word_t;
    typedef logic [OPCODE_W-1:0]       opcode_t;
    typedef logic [POS_W-1:0]          position_t;
    typedef logic [OCC_W-1:0]          occupancy_t;
    typedef logic [STATUS_W-1:0]       status_t;

    typedef logic [PTR_W-1:0]          ptr_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [WORD_WIDTH-1:0]     slot_word_t;

    // Operation codes
    localparam opcode_t OP_PUSH_FRONT = 3'd0;
    localparam opcode_t OP_PUSH_BACK  = 3'd1;
    localparam opcode_t OP_POP_FRONT  = 3'd2;
    localparam opcode_t OP_POP_BACK   = 3'd3;
    localparam opcode_t OP_READ       = 3'd4;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    // Slot at a distance from base, wrapping at DEPTH (off stays below DEPTH)
    function automatic ptr_t ring_add(input ptr_t base, input ptr_t off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W + 1)'(DEPTH)) begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Slot just before base, wrapping at DEPTH
    function automatic ptr_t ring_dec(input ptr_t base);
        ptr_t res;
        if (base == '0) begin
            res = PTR_W'(DEPTH - 1);
        end else begin
            res = base - PTR_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: design/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of 32-bit words in a ring buffer
// One word in, one result word out per operation; storage in a dual-read RAM.
// ----------------------------------------------------------------------------
// Each input word carries one operation (push front, push back, pop front,
// pop back, read at position) and yields exactly one result word holding the
// front and back elements, the occupancy and empty flag after the operation,
// the word read for a read, and a status (ok, push dropped when full, pop on
// empty ignored, position out of range). Elements live in a 64-entry RAM with
// one write port and two registered read ports; the head slot and the count
// sit in registers. An operation goes through these steps in order: accept
// and update (including the RAM write for a push), read front and back
// through both ports, read the addressed element, then load the result
// register. The result register parts the two sides: the next word is
// accepted while a finished result still waits for m_ready, and the final
// step waits only if that register is still occupied. The RAM needs no
// clearing after reset, since only live slots are ever reported.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input word channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire dbq_pkg::opcode_t     s_opcode,
    input  wire dbq_pkg::field_word_t s_value,
    input  wire dbq_pkg::position_t   s_position,
    // result word channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output dbq_pkg::field_word_t      m_front_word,
    output dbq_pkg::field_word_t      m_back_word,
    output dbq_pkg::field_word_t      m_read_word,
    output dbq_pkg::occupancy_t       m_occupancy,
    output logic                      m_is_empty,
    output dbq_pkg::status_t          m_status
);
    import dbq_pkg::*;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // wait for a word, update pointers
    localparam logic [1:0] S_FB   = 2'd1;  // issue front/back reads
    localparam logic [1:0] S_RD   = 2'd2;  // capture front/back, issue position read
    localparam logic [1:0] S_OUT  = 2'd3;  // load the result register

    // Control state
    logic [1:0] state_reg, state_next;
    ptr_t       head_reg, head_next;
    cnt_t       count_reg, count_next;
    logic       m_valid_reg, m_valid_next;

    // Per-operation context (payload, no reset)
    status_t    status_reg, status_next;
    logic       rd_ok_reg, rd_ok_next;
    ptr_t       pos_reg, pos_next;
    slot_word_t front_q_reg, front_q_next;
    slot_word_t back_q_reg, back_q_next;

    // Result register
    field_word_t front_out_reg, front_out_next;
    field_word_t back_out_reg, back_out_next;
    field_word_t read_out_reg, read_out_next;
    occupancy_t  occ_out_reg, occ_out_next;
    logic        empty_out_reg, empty_out_next;
    status_t     status_out_reg, status_out_next;

    // RAM ports
    logic       ram_we;
    ptr_t       ram_waddr;
    slot_word_t ram_wdata;
    ptr_t       ram_raddr_a, ram_raddr_b;
    slot_word_t ram_rdata_a, ram_rdata_b;

    logic is_full;
    logic is_none;
    logic accept;
    logic out_free;

    dbq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_none  = (count_reg == '0);

    // Port A reads the front slot in S_FB, else the addressed slot.
    // Port B always follows the back slot.
    assign ram_raddr_a = (state_reg == S_FB) ? head_reg : ring_add(head_reg, pos_reg);
    assign ram_raddr_b = ring_add(head_reg, PTR_W'(count_reg - CNT_W'(1)));
    assign ram_wdata   = WORD_WIDTH'(s_value);

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg;
        status_next     = status_reg;
        rd_ok_next      = rd_ok_reg;
        pos_next        = pos_reg;
        front_q_next    = front_q_reg;
        back_q_next     = back_q_reg;
        front_out_next  = front_out_reg;
        back_out_next   = back_out_reg;
        read_out_next   = read_out_reg;
        occ_out_next    = occ_out_reg;
        empty_out_next  = empty_out_reg;
        status_out_next = status_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = ring_dec(head_reg);

        // Drop the result once the consumer takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next = ST_OK;
                    rd_ok_next  = 1'b0;
                    pos_next    = PTR_W'(s_position);
                    state_next  = S_FB;
                    case (s_opcode)
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                // Write just ahead of the head and move it
                                ram_we     = 1'b1;
                                ram_waddr  = ring_dec(head_reg);
                                head_next  = ring_dec(head_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = ring_add(head_reg, PTR_W'(count_reg));
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_none) begin
                                status_next = ST_EMPTY;
                            end else begin
                                head_next  = ring_add(head_reg, PTR_W'(1));
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_none) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (32'(s_position) >= 32'(count_reg)) begin
                                status_next = ST_RANGE;
                            end else begin
                                rd_ok_next = 1'b1;
                            end
                        end
                        default: begin
                            // unused codes leave the queue as is
                        end
                    endcase
                end
            end
            S_FB: begin
                state_next = S_RD;
            end
            S_RD: begin
                front_q_next = ram_rdata_a;
                back_q_next  = ram_rdata_b;
                state_next   = S_OUT;
            end
            S_OUT: begin
                // Hold here while the previous result is still waiting
                if (out_free) begin
                    front_out_next  = is_none ? '0 : FIELD_W'(front_q_reg);
                    back_out_next   = is_none ? '0 : FIELD_W'(back_q_reg);
                    read_out_next   = rd_ok_reg ? FIELD_W'(ram_rdata_a) : '0;
                    occ_out_next    = OCC_W'(count_reg);
                    empty_out_next  = is_none;
                    status_out_next = status_reg;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg     <= status_next;
        rd_ok_reg      <= rd_ok_next;
        pos_reg        <= pos_next;
        front_q_reg    <= front_q_next;
        back_q_reg     <= back_q_next;
        front_out_reg  <= front_out_next;
        back_out_reg   <= back_out_next;
        read_out_reg   <= read_out_next;
        occ_out_reg    <= occ_out_next;
        empty_out_reg  <= empty_out_next;
        status_out_reg <= status_out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_front_word = front_out_reg;
    assign m_back_word  = back_out_reg;
    assign m_read_word  = read_out_reg;
    assign m_occupancy  = occ_out_reg;
    assign m_is_empty   = empty_out_reg;
    assign m_status     = status_out_reg;

endmodule
`default_nettype wire

FILE: design/dbq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbq_ram: generic synchronous RAM, one write port, two registered read ports
// Read data appears in the cycle after the address; a read in the cycle after a
// write to the same entry returns the new word.
// ----------------------------------------------------------------------------
module dbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_a <= mem_array[raddr_a];
        rdata_b <= mem_array[raddr_b];
    end

endmodule
`default_nettype wire

FILE: tb/deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker: result predictor and scoreboard for double_ended_queue
// Mirrors the ring buffer on every accepted input word, queues the expected
// result word and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module deque_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  dbq_pkg::opcode_t     s_opcode,
    input  dbq_pkg::field_word_t s_value,
    input  dbq_pkg::position_t   s_position,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  dbq_pkg::field_word_t m_front_word,
    input  dbq_pkg::field_word_t m_back_word,
    input  dbq_pkg::field_word_t m_read_word,
    input  dbq_pkg::occupancy_t  m_occupancy,
    input  logic                 m_is_empty,
    input  dbq_pkg::status_t     m_status,
    output int                   fail_count,
    output int                   outstanding
);
    import dbq_pkg::*;

    typedef struct packed {
        field_word_t front_word;
        field_word_t back_word;
        field_word_t read_word;
        occupancy_t  occupancy;
        logic        is_empty;
        status_t     status;
    } deque_result_t;

    // Mirror of the ring buffer
    slot_word_t    ring [DEPTH];
    ptr_t          front_slot;
    cnt_t          held;

    deque_result_t expected_results [$];
    deque_result_t got;
    deque_result_t want;
    int            mismatches;
    int            words_seen;

    initial begin
        fail_count  = 0;
        outstanding = 0;
        mismatches  = 0;
        words_seen  = 0;
        front_slot  = '0;
        held        = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, words_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] seen,
                               input logic [31:0] wanted);
        if (seen !== wanted) begin
            report_mismatch($sformatf("%s got %h, want %h", name, seen, wanted));
        end
    endtask

    // Apply one operation to the mirror and return the result it yields
    function automatic deque_result_t apply_operation(input opcode_t op,
                                                      input field_word_t val,
                                                      input position_t pos);
        deque_result_t r;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (held == cnt_t'(DEPTH)) begin
                    r.status = ST_FULL;
                end else begin
                    front_slot       = front_slot - 1'b1;
                    ring[front_slot] = slot_word_t'(val);
                    held++;
                end
            end
            OP_PUSH_BACK: begin
                if (held == cnt_t'(DEPTH)) begin
                    r.status = ST_FULL;
                end else begin
                    ring[ptr_t'(front_slot + held)] = slot_word_t'(val);
                    held++;
                end
            end
            OP_POP_FRONT: begin
                if (held == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    front_slot = front_slot + 1'b1;
                    held--;
                end
            end
            OP_POP_BACK: begin
                if (held == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    held--;
                end
            end
            OP_READ: begin
                if (cnt_t'(pos) >= held) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_word = field_word_t'(ring[ptr_t'(front_slot + pos)]);
                end
            end
            default: begin
            end
        endcase
        if (held != '0) begin
            r.front_word = field_word_t'(ring[front_slot]);
            r.back_word  = field_word_t'(ring[ptr_t'(front_slot + held - 1'b1)]);
        end
        r.occupancy = occupancy_t'(held);
        r.is_empty  = (held == '0);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            front_slot = '0;
            held       = '0;
            expected_results.delete();
        end else begin
            // Retire first: a result never belongs to a word accepted this edge
            if (m_valid && m_ready) begin
                words_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    got  = '{m_front_word, m_back_word, m_read_word,
                             m_occupancy, m_is_empty, m_status};
                    check_field("front_word", got.front_word, want.front_word);
                    check_field("back_word", got.back_word, want.back_word);
                    check_field("read_word", got.read_word, want.read_word);
                    check_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
                    check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                    check_field("status", 32'(got.status), 32'(want.status));
                end
            end
            if (s_valid && s_ready) begin
                expected_results = {expected_results,
                                    apply_operation(s_opcode, s_value, s_position)};
            end
        end
        fail_count  <= mismatches;
        outstanding <= expected_results.size();
    end

endmodule

FILE: tb/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue: stimulus and verdict for the double-ended queue
// Drives directed corner words, then biased random fill/drain/mixed traffic
// under three idling profiles; deque_checker predicts and scores results.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import dbq_pkg::*;

    // Opcodes the block treats as no operation
    localparam opcode_t OP_FIRST_UNUSED = 3'd5;
    localparam opcode_t OP_LAST_UNUSED  = 3'd7;

    localparam field_word_t WORD_MIN = 32'sh8000_0000;
    localparam field_word_t WORD_MAX = 32'sh7FFF_FFFF;

    // Random words per idling profile (three profiles)
    localparam int WORDS_PER_PROFILE = 300;
    // Hard stop: far beyond the slowest legal run of ~1000 words
    localparam int CYCLE_LIMIT       = 400_000;
    // Settle time at the end, beyond the depth of the result pipeline
    localparam int SETTLE_CYCLES     = 16;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    opcode_t     s_opcode    = OP_PUSH_BACK;
    field_word_t s_value     = '0;
    position_t   s_position  = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    field_word_t m_front_word;
    field_word_t m_back_word;
    field_word_t m_read_word;
    occupancy_t  m_occupancy;
    logic        m_is_empty;
    status_t     m_status;

    int          fail_count;
    int          outstanding;
    int          idle_pct    = 18;
    int          stall_pct   = 73;
    int          cycle_count = 0;

    double_ended_queue u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_front_word (m_front_word),
        .m_back_word  (m_back_word),
        .m_read_word  (m_read_word),
        .m_occupancy  (m_occupancy),
        .m_is_empty   (m_is_empty),
        .m_status     (m_status)
    );

    deque_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_front_word (m_front_word),
        .m_back_word  (m_back_word),
        .m_read_word  (m_read_word),
        .m_occupancy  (m_occupancy),
        .m_is_empty   (m_is_empty),
        .m_status     (m_status),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: stall at the current rate, one fresh draw per cycle
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one word: idle at the current rate first, then hold valid and
    // payload steady until the block takes it. Valid stays high on return
    // so back-to-back words need no drop in between.
    task automatic send_word(input opcode_t op, input field_word_t val,
                             input position_t pos);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_value    <= val;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly full-range random words, with the sign boundaries mixed in
    function automatic field_word_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)       return WORD_MIN;
        else if (r < 6)  return WORD_MAX;
        else if (r < 8)  return '0;
        else if (r < 10) return '1;
        else             return field_word_t'($urandom());
    endfunction

    // Fill mode drives the queue into the full state, drain mode back to
    // empty, mixed mode exercises reads and the unused opcodes.
    function automatic opcode_t pick_op(input traffic_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 85)      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else if (r < 95) return OP_READ;
                else             return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            end
            MODE_DRAIN: begin
                if (r < 80)      return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                else if (r < 95) return OP_READ;
                else             return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end
            default: begin
                if (r < 30)      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else if (r < 55) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                else if (r < 93) return OP_READ;
                else             return opcode_t'($urandom_range(OP_FIRST_UNUSED,
                                                                 OP_LAST_UNUSED));
            end
        endcase
    endfunction

    initial begin
        traffic_mode_t mode;
        int            burst_left;
        int            profile;
        int            n;

        // Hold reset low from the start, then release it synchronously
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- Directed corners (first idling profile) ----
        // Pops and a read on the empty queue
        send_word(OP_POP_FRONT, 32'sd1, 6'd0);
        send_word(OP_POP_BACK, 32'sd2, 6'd0);
        send_word(OP_READ, 32'sd3, 6'd0);
        // Extremes of the word at both ends; push front wraps the head slot
        send_word(OP_PUSH_BACK, WORD_MAX, 6'd63);
        send_word(OP_PUSH_FRONT, WORD_MIN, 6'd0);
        send_word(OP_PUSH_BACK, '0, 6'd0);
        send_word(OP_PUSH_FRONT, '1, 6'd0);
        // Reads at the front, the back, one past the back and the top index
        send_word(OP_READ, 32'sd0, 6'd0);
        send_word(OP_READ, 32'sd0, 6'd3);
        send_word(OP_READ, 32'sd0, 6'd4);
        send_word(OP_READ, '1, 6'd63);
        // Opcodes with no operation behind them
        send_word(OP_FIRST_UNUSED, 32'sh1234_5678, 6'd1);
        send_word(opcode_t'(OP_FIRST_UNUSED + 1'b1), 32'sh5A5A_5A5A, 6'd2);
        send_word(OP_LAST_UNUSED, '1, 6'd63);
        // Drain to empty, then one pop too many
        send_word(OP_POP_BACK, '0, 6'd0);
        send_word(OP_POP_FRONT, '0, 6'd0);
        send_word(OP_POP_FRONT, '0, 6'd0);
        send_word(OP_POP_BACK, '0, 6'd0);
        send_word(OP_POP_BACK, '0, 6'd0);
        // Alternating bit patterns, then read and pop
        send_word(OP_PUSH_FRONT, 32'sh5555_5555, 6'd0);
        send_word(OP_PUSH_BACK, 32'shAAAA_AAAA, 6'd0);
        send_word(OP_READ, 32'sd0, 6'd1);
        send_word(OP_POP_FRONT, '0, 6'd0);

        // ---- Random traffic in bursts of one mode each ----
        burst_left = 0;
        mode       = MODE_MIXED;
        for (profile = 0; profile < 3; profile++) begin
            // Light sender idling with heavy result stalls, then the reverse,
            // then full rate on both sides
            case (profile)
                0: begin idle_pct = 18; stall_pct = 73; end
                1: begin idle_pct = 73; stall_pct = 18; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (n = 0; n < WORDS_PER_PROFILE; n++) begin
                if (burst_left == 0) begin
                    mode       = traffic_mode_t'($urandom_range(0, 2));
                    burst_left = $urandom_range(20, 120);
                end
                burst_left--;
                send_word(pick_op(mode), pick_value(),
                          $urandom_range(0, 1) ? position_t'($urandom_range(0, 7))
                                               : position_t'($urandom()));
            end
        end
        s_valid <= 1'b0;

        // Let the result side run free and wait for every expected word
        stall_pct = 0;
        while (outstanding != 0) @(posedge aclk);
        // Settle, so any stray extra result word is caught too
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
design/dbq_pkg.sv
design/dbq_ram.sv
design/double_ended_queue.sv
tb/deque_checker.sv
tb/tb_double_ended_queue.sv
